// ===== hw/rtl/tacc_pkg.sv =====
// Package: shared types, side codes and helpers for the tracked-area crossing counter.
`timescale 1ns / 1ps
package tacc_pkg;

  localparam int unsigned CNT_W = 24;
  localparam int unsigned TOT_W = 26;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    SIDE_UP    = 3'd0,
    SIDE_DOWN  = 3'd1,
    SIDE_LEFT  = 3'd2,
    SIDE_RIGHT = 3'd3,
    SIDE_NONE  = 3'd4
  } side_t;

  typedef enum logic [1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_RIGHT  = 2'd2,
    CFG_BOTTOM = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DET,
    ST_FCAP,
    ST_FMUL,
    ST_FUPD,
    ST_FSUM,
    ST_FOUT
  } st_t;

  typedef struct packed {
    logic               act;
    logic               frame;
    logic               pass2;
    logic               done;
    logic [15:0]        id;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } tok_t;

  typedef struct packed {
    logic               valid;
    logic               seen;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] px;
    logic signed [15:0] py;
    side_t              es;
    side_t              xs;
  } entry_t;

  typedef struct packed {
    logic  we;
    logic  is_exit;
    side_t side;
  } wb_t;

  function automatic logic inside_area(
    input logic signed [15:0] x,
    input logic signed [15:0] y,
    input logic signed [15:0] l,
    input logic signed [15:0] t,
    input logic signed [15:0] r,
    input logic signed [15:0] b
  );
    return (x >= l) && (x <= r) && (y >= t) && (y <= b);
  endfunction

endpackage

// ===== hw/rtl/tacc_cell.sv =====
// One table slot: holds a tracked person and passes the request token on.
`timescale 1ns / 1ps
module tacc_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  tacc_pkg::tok_t  tok_in,
  output tacc_pkg::tok_t  tok_out,
  input  tacc_pkg::wb_t   wb,
  output logic            here,
  output tacc_pkg::entry_t tap
);
  import tacc_pkg::*;

  logic               valid_r, valid_nxt;
  logic               seen_r, seen_nxt;
  logic [15:0]        person_r;
  logic signed [15:0] cx_r, cy_r, px_r, py_r;
  side_t              es_r, xs_r;
  tok_t               tok_r, tok_nxt;
  logic               hit, alloc;

  assign here = tok_in.act && tok_in.frame;
  assign hit = adv && tok_in.act && !tok_in.frame && !tok_in.pass2 && !tok_in.done &&
               valid_r && (person_r == tok_in.id);
  assign alloc = adv && tok_in.act && !tok_in.frame && tok_in.pass2 && !tok_in.done &&
                 !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    seen_nxt  = seen_r;
    tok_nxt   = tok_r;
    if (adv) begin
      tok_nxt = tok_in;
      if (hit || alloc) begin
        tok_nxt.done = 1'b1;
        valid_nxt    = 1'b1;
        seen_nxt     = 1'b1;
      end
      if (here) begin
        valid_nxt = valid_r && seen_r;
        seen_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seen_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      seen_r  <= seen_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      px_r <= cx_r;
      py_r <= cy_r;
      cx_r <= tok_in.x;
      cy_r <= tok_in.y;
    end else if (alloc) begin
      person_r <= tok_in.id;
      px_r     <= tok_in.x;
      py_r     <= tok_in.y;
      cx_r     <= tok_in.x;
      cy_r     <= tok_in.y;
      es_r     <= SIDE_NONE;
      xs_r     <= SIDE_NONE;
    end
    if (wb.we && here) begin
      if (wb.is_exit) begin
        xs_r <= wb.side;
      end else begin
        es_r <= wb.side;
      end
    end
  end

  assign tok_out = tok_r;

  always_comb begin
    tap = '0;
    if (here) begin
      tap.valid = valid_r;
      tap.seen  = seen_r;
      tap.cx    = cx_r;
      tap.cy    = cy_r;
      tap.px    = px_r;
      tap.py    = py_r;
      tap.es    = es_r;
      tap.xs    = xs_r;
    end
  end

endmodule

// ===== hw/rtl/tacc_ctrl.sv =====
// Sequencer: injects requests, classifies crossings and keeps the counters.
`timescale 1ns / 1ps
module tacc_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [15:0]              in_person_id,
  input  logic signed [15:0]       in_pos_x,
  input  logic signed [15:0]       in_pos_y,
  input  logic signed [15:0]       area_left,
  input  logic signed [15:0]       area_top,
  input  logic signed [15:0]       area_right,
  input  logic signed [15:0]       area_bottom,
  output tacc_pkg::tok_t           inj,
  input  tacc_pkg::tok_t           chain_out,
  input  tacc_pkg::entry_t         tap,
  output logic                     adv,
  output tacc_pkg::wb_t            wb,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [4:0]               out_in_area,
  output logic [tacc_pkg::CNT_W-1:0] out_enter_up,
  output logic [tacc_pkg::CNT_W-1:0] out_enter_down,
  output logic [tacc_pkg::CNT_W-1:0] out_enter_left,
  output logic [tacc_pkg::CNT_W-1:0] out_enter_right,
  output logic [tacc_pkg::CNT_W-1:0] out_exit_up,
  output logic [tacc_pkg::CNT_W-1:0] out_exit_down,
  output logic [tacc_pkg::CNT_W-1:0] out_exit_left,
  output logic [tacc_pkg::CNT_W-1:0] out_exit_right,
  output logic [tacc_pkg::TOT_W-1:0] out_total_enter,
  output logic [tacc_pkg::TOT_W-1:0] out_total_exit,
  output logic                     out_table_overflow
);
  import tacc_pkg::*;

  st_t                state_r, state_nxt;
  tok_t               inj_r, inj_nxt;
  logic [4:0]         in_area_r, in_area_nxt;
  logic [CNT_W-1:0]   en_r [4];
  logic [CNT_W-1:0]   ex_r [4];
  logic [CNT_W-1:0]   cnt_tmp [4];
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] pt_x_r, pt_y_r;
  logic               is_exit_r;
  side_t              old_side_r;
  logic signed [33:0] p_dy_r, p1_r, p2_r;
  logic [TOT_W-1:0]   te_r, tx_r;
  logic               now_in, was_in, act, crossing, cap, upd, sum, load;
  logic signed [16:0] w, h, a, b, c;
  logic signed [34:0] d1, d2;
  logic               n1, p1, n2, p2;
  side_t              side;

  logic [4:0]         o_area_r;
  logic [CNT_W-1:0]   o_en_r [4];
  logic [CNT_W-1:0]   o_ex_r [4];
  logic [TOT_W-1:0]   o_te_r, o_tx_r;
  logic               o_ovf_r;

  assign now_in   = inside_area(tap.cx, tap.cy, area_left, area_top, area_right, area_bottom);
  assign was_in   = inside_area(tap.px, tap.py, area_left, area_top, area_right, area_bottom);
  assign act      = tap.valid && tap.seen;
  assign crossing = act && (now_in != was_in);

  assign w = {area_right[15], area_right} - {area_left[15], area_left};
  assign h = {area_bottom[15], area_bottom} - {area_top[15], area_top};
  assign a = {pt_y_r[15], pt_y_r} - {area_top[15], area_top};
  assign b = {pt_x_r[15], pt_x_r} - {area_left[15], area_left};
  assign c = {area_right[15], area_right} - {pt_x_r[15], pt_x_r};

  assign d1 = {p_dy_r[33], p_dy_r} - {p1_r[33], p1_r};
  assign d2 = {p_dy_r[33], p_dy_r} - {p2_r[33], p2_r};
  assign n1 = d1[34] || (d1 == '0);
  assign p1 = !d1[34];
  assign n2 = d2[34] || (d2 == '0);
  assign p2 = !d2[34];

  always_comb begin
    if (n1 && n2) begin
      side = SIDE_UP;
    end else if (p1 && p2) begin
      side = SIDE_DOWN;
    end else if (p1 && n2) begin
      side = SIDE_LEFT;
    end else begin
      side = SIDE_RIGHT;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_tmp[i] = is_exit_r ? ex_r[i] : en_r[i];
    end
    if (!old_side_r[2] && (cnt_tmp[old_side_r[1:0]] != '0)) begin
      cnt_tmp[old_side_r[1:0]] = cnt_tmp[old_side_r[1:0]] - 1'b1;
    end
    if (cnt_tmp[side[1:0]] != CNT_MAX) begin
      cnt_tmp[side[1:0]] = cnt_tmp[side[1:0]] + 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    inj_nxt       = inj_r;
    in_area_nxt   = in_area_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    adv           = 1'b0;
    cap           = 1'b0;
    upd           = 1'b0;
    sum           = 1'b0;
    load          = 1'b0;
    in_ready      = 1'b0;
    wb            = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          inj_nxt.act   = 1'b1;
          inj_nxt.frame = in_cmd;
          inj_nxt.pass2 = 1'b0;
          inj_nxt.done  = 1'b0;
          inj_nxt.id    = in_person_id;
          inj_nxt.x     = in_pos_x;
          inj_nxt.y     = in_pos_y;
          if (in_cmd) begin
            in_area_nxt = '0;
            state_nxt   = ST_FCAP;
          end else begin
            state_nxt = ST_DET;
          end
        end
      end
      ST_DET: begin
        adv     = 1'b1;
        inj_nxt = '0;
        if (chain_out.act) begin
          if (chain_out.done) begin
            state_nxt = ST_IDLE;
          end else if (!chain_out.pass2) begin
            inj_nxt       = chain_out;
            inj_nxt.pass2 = 1'b1;
          end else begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FCAP: begin
        if (chain_out.act) begin
          adv       = 1'b1;
          inj_nxt   = '0;
          state_nxt = ST_FSUM;
        end else begin
          if (act && now_in && (in_area_r != 5'd31)) begin
            in_area_nxt = in_area_r + 5'd1;
          end
          if (crossing) begin
            cap       = 1'b1;
            state_nxt = ST_FMUL;
          end else begin
            adv     = 1'b1;
            inj_nxt = '0;
          end
        end
      end
      ST_FMUL: begin
        state_nxt = ST_FUPD;
      end
      ST_FUPD: begin
        upd        = 1'b1;
        adv        = 1'b1;
        inj_nxt    = '0;
        wb.we      = 1'b1;
        wb.is_exit = is_exit_r;
        wb.side    = side;
        state_nxt  = ST_FCAP;
      end
      ST_FSUM: begin
        sum       = 1'b1;
        state_nxt = ST_FOUT;
      end
      ST_FOUT: begin
        if (!out_valid_r || out_ready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inj_r       <= '0;
      in_area_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        en_r[i] <= '0;
        ex_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      inj_r       <= inj_nxt;
      in_area_r   <= in_area_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd) begin
        for (int i = 0; i < 4; i++) begin
          if (is_exit_r) begin
            ex_r[i] <= cnt_tmp[i];
          end else begin
            en_r[i] <= cnt_tmp[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      is_exit_r  <= was_in;
      old_side_r <= was_in ? tap.xs : tap.es;
      pt_x_r     <= was_in ? tap.cx : tap.px;
      pt_y_r     <= was_in ? tap.cy : tap.py;
    end
    if (state_r == ST_FMUL) begin
      p_dy_r <= a * w;
      p1_r   <= h * b;
      p2_r   <= h * c;
    end
    if (sum) begin
      te_r <= TOT_W'(en_r[0]) + TOT_W'(en_r[1]) + TOT_W'(en_r[2]) + TOT_W'(en_r[3]);
      tx_r <= TOT_W'(ex_r[0]) + TOT_W'(ex_r[1]) + TOT_W'(ex_r[2]) + TOT_W'(ex_r[3]);
    end
    if (load) begin
      o_area_r <= in_area_r;
      o_te_r   <= te_r;
      o_tx_r   <= tx_r;
      o_ovf_r  <= ovf_r;
      for (int i = 0; i < 4; i++) begin
        o_en_r[i] <= en_r[i];
        o_ex_r[i] <= ex_r[i];
      end
    end
  end

  assign inj                = inj_r;
  assign out_valid          = out_valid_r;
  assign out_in_area        = o_area_r;
  assign out_enter_up       = o_en_r[SIDE_UP[1:0]];
  assign out_enter_down     = o_en_r[SIDE_DOWN[1:0]];
  assign out_enter_left     = o_en_r[SIDE_LEFT[1:0]];
  assign out_enter_right    = o_en_r[SIDE_RIGHT[1:0]];
  assign out_exit_up        = o_ex_r[SIDE_UP[1:0]];
  assign out_exit_down      = o_ex_r[SIDE_DOWN[1:0]];
  assign out_exit_left      = o_ex_r[SIDE_LEFT[1:0]];
  assign out_exit_right     = o_ex_r[SIDE_RIGHT[1:0]];
  assign out_total_enter    = o_te_r;
  assign out_total_exit     = o_tx_r;
  assign out_table_overflow = o_ovf_r;

  a_tok_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    chain_out.act |-> (state_r == ST_DET || state_r == ST_FCAP))
    else $error("request left the chain outside a walk");

  a_upd_returns: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FUPD |=> state_r == ST_FCAP)
    else $error("counter update did not return to capture");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ovf_r) |-> ovf_r)
    else $error("overflow flag cleared");

endmodule

// ===== hw/rtl/tracked_area_crossing_counter_top.sv =====
// Top level: configuration registers, the row of table cells and the sequencer.
`timescale 1ns / 1ps
// A detection request walks the row of cells one cell per cycle, once to find the
// person and, if it is not found, once more to open a slot.
// A frame-end request walks the row once and holds at each entry that crosses the
// area edge while the shared side classifier works on it; one result follows it.
module tracked_area_crossing_counter_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [15:0]                in_person_id,
  input  logic signed [15:0]         in_pos_x,
  input  logic signed [15:0]         in_pos_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [4:0]                 out_in_area,
  output logic [tacc_pkg::CNT_W-1:0] out_enter_up,
  output logic [tacc_pkg::CNT_W-1:0] out_enter_down,
  output logic [tacc_pkg::CNT_W-1:0] out_enter_left,
  output logic [tacc_pkg::CNT_W-1:0] out_enter_right,
  output logic [tacc_pkg::CNT_W-1:0] out_exit_up,
  output logic [tacc_pkg::CNT_W-1:0] out_exit_down,
  output logic [tacc_pkg::CNT_W-1:0] out_exit_left,
  output logic [tacc_pkg::CNT_W-1:0] out_exit_right,
  output logic [tacc_pkg::TOT_W-1:0] out_total_enter,
  output logic [tacc_pkg::TOT_W-1:0] out_total_exit,
  output logic                       out_table_overflow,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_wdata
);
  import tacc_pkg::*;

  logic signed [15:0] left_r, top_r, right_r, bottom_r;
  tok_t               chain [TABLE_ENTRIES+1];
  entry_t             taps [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] here_v;
  entry_t             tap;
  logic               adv;
  wb_t                wb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= -16'sd3235;
      top_r    <= -16'sd3219;
      right_r  <= 16'sd3263;
      bottom_r <= -16'sd2937;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEFT:   left_r   <= cfg_wdata;
        CFG_TOP:    top_r    <= cfg_wdata;
        CFG_RIGHT:  right_r  <= cfg_wdata;
        CFG_BOTTOM: bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    tacc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1]),
      .wb      (wb),
      .here    (here_v[k]),
      .tap     (taps[k])
    );
  end

  always_comb begin
    tap = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      tap = tap | taps[k];
    end
  end

  tacc_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_person_id       (in_person_id),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .area_left          (left_r),
    .area_top           (top_r),
    .area_right         (right_r),
    .area_bottom        (bottom_r),
    .inj                (chain[0]),
    .chain_out          (chain[TABLE_ENTRIES]),
    .tap                (tap),
    .adv                (adv),
    .wb                 (wb),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_in_area        (out_in_area),
    .out_enter_up       (out_enter_up),
    .out_enter_down     (out_enter_down),
    .out_enter_left     (out_enter_left),
    .out_enter_right    (out_enter_right),
    .out_exit_up        (out_exit_up),
    .out_exit_down      (out_exit_down),
    .out_exit_left      (out_exit_left),
    .out_exit_right     (out_exit_right),
    .out_total_enter    (out_total_enter),
    .out_total_exit     (out_total_exit),
    .out_table_overflow (out_table_overflow)
  );

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(here_v))
    else $error("frame request held by more than one cell");

endmodule
